// ===== hdl/slm_pkg.sv =====
// Shared types and command codes for the sorted list merge unit.
`timescale 1ns / 1ps

package slm_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
    } slm_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic                      last;
        logic                      overflow;
    } slm_out_t;

    // Queue entry passed from the front end to the back end.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } slm_req_t;

endpackage

// ===== hdl/sorted_list_merge_unit.sv =====
// Top level of the sorted list merge unit: front end queue and merge back end.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low, and it waits
// in the queue until the back end is idle and takes it. Appends to list A or B
// retire at one per cycle while no merge runs. A merge occupies the back end from
// the cycle that takes it from the queue, through the priming state that reads both
// list heads through the registered read port of each list RAM, then one result per
// cycle; the first result is driven in the state that follows priming. A merge
// of two empty lists gives no result. Requests keep being taken into a queue of
// QUEUE_DEPTH entries while a merge runs, and busy rises only when that queue is
// full. Each result appears for exactly one cycle with strobe high and cannot be
// held off by the receiver. Unused command code 3 is accepted and discarded.
module sorted_list_merge_unit #(
    parameter int LIST_DEPTH  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  slm_pkg::slm_in_t  request,
    output logic              strobe,
    output slm_pkg::slm_out_t result
);

    import slm_pkg::*;

    logic     q_valid;
    slm_req_t q_head;
    logic     pop;

    slm_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .q_valid(q_valid),
        .q_head (q_head),
        .pop    (pop)
    );

    slm_back #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_head (q_head),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

// ===== hdl/slm_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module slm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/slm_front.sv =====
// Front end: accepts requests, drops the unused command code, queues the rest.
`timescale 1ns / 1ps

module slm_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  slm_pkg::slm_in_t  request,
    output logic              q_valid,
    output slm_pkg::slm_req_t q_head,
    input  logic              pop
);

    import slm_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    slm_req_t       q_mem_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wptr_reg, wptr_next;
    logic [QAW-1:0] rptr_reg, rptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           accept;
    logic           push;
    slm_req_t       entry;

    assign busy    = (count_reg == QCW'(QUEUE_DEPTH));
    assign accept  = start && !busy;
    assign push    = accept && (request.cmd != CMD_RESERVED);
    assign q_valid = (count_reg != '0);
    assign q_head  = q_mem_reg[rptr_reg];

    always_comb
    begin
        entry.cmd   = request.cmd;
        entry.value = request.value;
    end

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wptr_reg] <= entry;
        end
    end

endmodule

// ===== hdl/slm_back.sv =====
// Back end: stores appended values in two list RAMs and runs the merge.
`timescale 1ns / 1ps

module slm_back #(
    parameter int LIST_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  slm_pkg::slm_req_t q_head,
    output logic              pop,
    output logic              strobe,
    output slm_pkg::slm_out_t result
);

    import slm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_a_reg, cnt_a_next;
    logic [CW-1:0]      cnt_b_reg, cnt_b_next;
    logic [CW-1:0]      ia_reg, ia_next;
    logic [CW-1:0]      ib_reg, ib_next;
    logic               flag_reg, flag_next;
    logic               we_a, we_b;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic [VALUE_W-1:0] rd_a, rd_b;
    logic               take_a;
    logic               is_last;
    logic [CW-1:0]      ia_inc, ib_inc;

    assign pop    = (state_reg == ST_IDLE) && q_valid;
    assign we_a   = pop && (q_head.cmd == CMD_APPEND_A) && (cnt_a_reg != CW'(LIST_DEPTH));
    assign we_b   = pop && (q_head.cmd == CMD_APPEND_B) && (cnt_b_reg != CW'(LIST_DEPTH));
    assign ia_inc = ia_reg + 1'b1;
    assign ib_inc = ib_reg + 1'b1;

    // A wins ties so equal values leave in list A before list B.
    assign take_a = (ia_reg < cnt_a_reg)
                 && ((ib_reg >= cnt_b_reg) || ($signed(rd_a) <= $signed(rd_b)));
    assign is_last = take_a ? ((ia_inc == cnt_a_reg) && (ib_reg == cnt_b_reg))
                            : ((ib_inc == cnt_b_reg) && (ia_reg == cnt_a_reg));

    // The side that advances reads its next entry; the other side re-reads its head.
    assign raddr_a = ((state_reg == ST_EMIT) && take_a)  ? ia_inc[AW-1:0] : ia_reg[AW-1:0];
    assign raddr_b = ((state_reg == ST_EMIT) && !take_a) ? ib_inc[AW-1:0] : ib_reg[AW-1:0];

    assign strobe              = (state_reg == ST_EMIT);
    assign result.merged_value = take_a ? rd_a : rd_b;
    assign result.last         = is_last;
    assign result.overflow     = flag_reg;

    slm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(LIST_DEPTH),
        .AW   (AW)
    ) u_ram_a (
        .clk  (clk),
        .we   (we_a),
        .waddr(cnt_a_reg[AW-1:0]),
        .wdata(q_head.value),
        .raddr(raddr_a),
        .rdata(rd_a)
    );

    slm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(LIST_DEPTH),
        .AW   (AW)
    ) u_ram_b (
        .clk  (clk),
        .we   (we_b),
        .waddr(cnt_b_reg[AW-1:0]),
        .wdata(q_head.value),
        .raddr(raddr_b),
        .rdata(rd_b)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        flag_next  = flag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (q_head.cmd)
                        CMD_APPEND_A:
                        begin
                            if (we_a)
                            begin
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            else
                            begin
                                flag_next = 1'b1;
                            end
                        end
                        CMD_APPEND_B:
                        begin
                            if (we_b)
                            begin
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                flag_next = 1'b1;
                            end
                        end
                        CMD_MERGE:
                        begin
                            ia_next    = '0;
                            ib_next    = '0;
                            state_next = ST_PRIME;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PRIME:
            begin
                // Both heads are being read this cycle.
                if ((cnt_a_reg == '0) && (cnt_b_reg == '0))
                begin
                    flag_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (take_a)
                begin
                    ia_next = ia_inc;
                end
                else
                begin
                    ib_next = ib_inc;
                end
                if (is_last)
                begin
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ia_next    = '0;
                    ib_next    = '0;
                    flag_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ia_reg    <= '0;
            ib_reg    <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
            flag_reg  <= flag_next;
        end
    end

    a_emit_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((ia_reg < cnt_a_reg) || (ib_reg < cnt_b_reg)))
        else $error("merge emitted with both lists drained");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> strobe)
        else $error("merge run broke off before its last element");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> ((cnt_a_reg == '0) && (cnt_b_reg == '0) && !flag_reg))
        else $error("lists not cleared after the last merged element");

    a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pop)
        else $error("request taken from the queue during a merge");

endmodule

// ===== sim/slm_scoreboard_pkg.sv =====
// Merge predictor and scoreboard for the sorted list merge unit testbench.
`timescale 1ns / 1ps

package slm_scoreboard_pkg;

    import slm_pkg::*;

    localparam int LIST_DEPTH = 32;
    localparam int SHOW_LIMIT = 10;

    class merge_scoreboard;

        logic signed [VALUE_W-1:0] list_a [LIST_DEPTH];
        logic signed [VALUE_W-1:0] list_b [LIST_DEPTH];
        int unsigned               count_a;
        int unsigned               count_b;
        bit                        dropped;
        slm_out_t                  merge_queue [$];
        int                        errors;
        int                        shown;

        function new();
            count_a = 0;
            count_b = 0;
            dropped = 1'b0;
            errors  = 0;
            shown   = 0;
        endfunction

        function int pending();
            return merge_queue.size();
        endfunction

        // Works out what an accepted request produces and queues those results.
        function void note_request(slm_in_t req);
            int unsigned ia;
            int unsigned ib;
            int unsigned total;
            slm_out_t    item;
            ia = 0;
            ib = 0;
            case (req.cmd)
                CMD_APPEND_A:
                begin
                    if (count_a < LIST_DEPTH)
                    begin
                        list_a[count_a] = req.value;
                        count_a++;
                    end
                    else
                        dropped = 1'b1;
                end
                CMD_APPEND_B:
                begin
                    if (count_b < LIST_DEPTH)
                    begin
                        list_b[count_b] = req.value;
                        count_b++;
                    end
                    else
                        dropped = 1'b1;
                end
                CMD_MERGE:
                begin
                    total = count_a + count_b;
                    for (int unsigned n = 0; n < total; n++)
                    begin
                        // Equal heads go out from list A first.
                        if (ia < count_a && (ib >= count_b || list_a[ia] <= list_b[ib]))
                        begin
                            item.merged_value = list_a[ia];
                            ia++;
                        end
                        else
                        begin
                            item.merged_value = list_b[ib];
                            ib++;
                        end
                        item.last     = (n + 1 == total);
                        item.overflow = dropped;
                        merge_queue = {merge_queue, item};
                    end
                    count_a = 0;
                    count_b = 0;
                    dropped = 1'b0;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(slm_out_t got);
            slm_out_t want;
            if (merge_queue.size() == 0)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                begin
                    shown++;
                    $display("unexpected result: value %0d last %0b overflow %0b",
                             got.merged_value, got.last, got.overflow);
                end
                return;
            end
            want = merge_queue.pop_front();
            if (got.merged_value !== want.merged_value || got.last !== want.last ||
                got.overflow !== want.overflow)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                begin
                    shown++;
                    $display({"result mismatch: expected value %0d last %0b overflow %0b,",
                              " got value %0d last %0b overflow %0b"},
                             want.merged_value, want.last, want.overflow,
                             got.merged_value, got.last, got.overflow);
                end
            end
        endfunction

    endclass

endpackage

// ===== sim/tb.sv =====
// Testbench top for the sorted list merge unit.
`timescale 1ns / 1ps

module tb;

    import slm_pkg::*;
    import slm_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 85;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    slm_in_t  request = '0;
    logic     strobe;
    slm_out_t result;

    merge_scoreboard sb = new();
    int              item_count = 0;
    bit              gappy = 1'b0;

    sorted_list_merge_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    always #6 clk = ~clk;

    // Outputs change only at rising edges, so the falling edge sees settled values.
    always @(negedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(result);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_value(bit ties);
        if (ties)
            return $urandom_range(0, 6) - 3;
        return $urandom;
    endfunction

    // Called at a rising edge; returns at the rising edge that took the request.
    task automatic issue(input logic [CMD_W-1:0] cmd, input int value);
        slm_in_t req;
        req.cmd   = cmd;
        req.value = value;
        start   <= 1'b1;
        request <= req;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        sb.note_request(req);
        item_count++;
        @(posedge clk);
    endtask

    task automatic pause();
        int n;
        n = gappy ? gap_len() : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Loads two lists with interleaved appends, then merges them.
    task automatic merge_run(input int na, input int nb, input bit ties, input bit sorted);
        int qa [$];
        int qb [$];
        for (int i = 0; i < na; i++)
            qa = {qa, pick_value(ties)};
        for (int i = 0; i < nb; i++)
            qb = {qb, pick_value(ties)};
        if (sorted)
        begin
            qa.sort();
            qb.sort();
        end
        while (qa.size() + qb.size() > 0)
        begin
            if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1) == 0))
                issue(CMD_APPEND_A, qa.pop_front());
            else
                issue(CMD_APPEND_B, qb.pop_front());
            pause();
        end
        issue(CMD_MERGE, $urandom);
        pause();
    endtask

    initial
    begin
        int target;
        int r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back.
        issue(CMD_MERGE, 0);
        issue(CMD_RESERVED, 32'h7FFF_FFFF);
        issue(CMD_APPEND_A, 32'h8000_0000);
        issue(CMD_APPEND_B, 32'h8000_0000);
        issue(CMD_APPEND_A, 0);
        issue(CMD_APPEND_B, 5);
        issue(CMD_APPEND_A, 5);
        issue(CMD_RESERVED, 32'h8000_0000);
        issue(CMD_APPEND_B, 32'h7FFF_FFFF);
        issue(CMD_MERGE, 32'hFFFF_FFFF);
        issue(CMD_APPEND_A, 7);
        issue(CMD_MERGE, 0);
        issue(CMD_APPEND_B, -1);
        issue(CMD_MERGE, 0);
        // Unsorted list A is merged as it stands.
        issue(CMD_APPEND_A, 10);
        issue(CMD_APPEND_A, 3);
        issue(CMD_APPEND_B, 4);
        issue(CMD_MERGE, 0);

        // Random part. The first run overfills both lists.
        target = item_count + RANDOM_ITEMS;
        gappy = 1'b1;
        merge_run(LIST_DEPTH + 1, LIST_DEPTH + 1, 1'b0, 1'b1);
        while (item_count < target)
        begin
            gappy = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    issue(CMD_W'($urandom_range(0, 3)), $urandom);
                    pause();
                end
            end
            else if (r == 2)
                merge_run($urandom_range(0, 5), $urandom_range(0, 5), 1'b0, 1'b0);
            else if (r == 3)
                merge_run($urandom_range(20, LIST_DEPTH + 2), $urandom_range(0, 3),
                          1'($urandom_range(0, 1)), 1'b1);
            else
                merge_run($urandom_range(0, 6), $urandom_range(0, 6),
                          $urandom_range(0, 2) == 0, 1'b1);
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS sorted_list_merge_unit");
        else
            $display("FAIL sorted_list_merge_unit");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL sorted_list_merge_unit");
        $finish;
    end

endmodule
